[hw/rtl/toa_pkg.sv]
package toa_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 9;

    // angle accumulator: degrees, 7 fraction bits
    localparam int ANGLE_FRAC = 7;
    localparam int Z_W        = 16;
    localparam int O_W        = 10;

    localparam int DEG_FULL    = 360;
    localparam int DEG_QUARTER = 90;
    localparam int TILT_SHIFT  = 2;   // x4 on the horizontal magnitude

    localparam logic signed [Z_W-1:0] Z_QUARTER  = Z_W'(DEG_QUARTER << ANGLE_FRAC);
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1 << (ANGLE_FRAC - 1));

    // rotation step index, covers up to 32 steps
    localparam int STEP_W = 5;

    typedef struct packed {
        logic              load;
        logic              sq_x;
        logic              sq_y;
        logic              sq_z;
        logic              rot;
        logic              result;
        logic              commit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic changed;
    } t_dp_stat;

    // atan(2^-i) in degrees, scaled by 128 and rounded
    function automatic logic signed [Z_W-1:0] atan_q7(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 16'sd5760;
            5'd1:    v = 16'sd3400;
            5'd2:    v = 16'sd1797;
            5'd3:    v = 16'sd912;
            5'd4:    v = 16'sd458;
            5'd5:    v = 16'sd229;
            5'd6:    v = 16'sd115;
            5'd7:    v = 16'sd57;
            5'd8:    v = 16'sd29;
            5'd9:    v = 16'sd14;
            5'd10:   v = 16'sd7;
            5'd11:   v = 16'sd4;
            5'd12:   v = 16'sd2;
            5'd13:   v = 16'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/toa_if.sv]
// sample channel
interface toa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [toa_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [toa_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [toa_pkg::SAMPLE_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

// orientation channel
interface toa_out_if;
    logic                         valid;
    logic                         ready;
    logic [toa_pkg::ANGLE_W-1:0]  angle_deg;
    logic                         angle_known;

    modport source (output valid, output angle_deg, output angle_known, input ready);
    modport sink   (input valid, input angle_deg, input angle_known, output ready);
endinterface

[hw/rtl/toa_ctrl.sv]
module toa_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  toa_pkg::t_dp_stat i_stat,
    output toa_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SQZ,
        S_ROT,
        S_RESULT,
        S_EMIT
    } t_state;

    localparam logic [toa_pkg::STEP_W-1:0] LastStep = toa_pkg::STEP_W'(CORDIC_STEPS - 1);

    t_state                      r_state;
    logic [toa_pkg::STEP_W-1:0]  r_step;
    logic                        r_out_valid;
    logic                        w_out_free;
    logic                        w_commit;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_EMIT) && i_stat.changed && w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.sq_x   = (r_state == S_SQX);
        o_cmd.sq_y   = (r_state == S_SQY);
        o_cmd.sq_z   = (r_state == S_SQZ);
        o_cmd.rot    = (r_state == S_ROT);
        o_cmd.result = (r_state == S_RESULT);
        o_cmd.commit = w_commit;
        o_cmd.step   = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: r_state <= S_SQZ;
                S_SQZ: begin
                    r_step  <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_step == LastStep) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_RESULT: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!i_stat.changed) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/toa_dp.sv]
module toa_dp #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  toa_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [toa_pkg::SAMPLE_W-1:0] i_accel_x,
    input  logic signed [toa_pkg::SAMPLE_W-1:0] i_accel_y,
    input  logic signed [toa_pkg::SAMPLE_W-1:0] i_accel_z,
    output toa_pkg::t_dp_stat                   o_stat,
    output logic [toa_pkg::ANGLE_W-1:0]         o_angle_deg,
    output logic                                o_angle_known
);

    localparam int SB  = SAMPLE_BITS;
    localparam int P_W = 2 * SAMPLE_BITS;
    localparam int CW  = SAMPLE_BITS + 3;
    localparam int ZW  = toa_pkg::Z_W;
    localparam int OW  = toa_pkg::O_W;
    localparam int AW  = toa_pkg::ANGLE_W;

    // samples: low SAMPLE_BITS bits of each field, sign-extended
    logic [SB-1:0]        w_rx, w_ry, w_rz;
    logic signed [SB-1:0] w_sx, w_sy, w_sz;

    assign w_rx = SB'($unsigned(i_accel_x));
    assign w_ry = SB'($unsigned(i_accel_y));
    assign w_rz = SB'($unsigned(i_accel_z));
    assign w_sx = $signed(w_rx);
    assign w_sy = $signed(w_ry);
    assign w_sz = $signed(w_rz);

    logic signed [SB-1:0] r_sx, r_sy, r_sz;
    logic [P_W-1:0]       r_acc, r_zsq;

    // shared squarer; squares of the negated axes equal those of the raw ones
    logic signed [SB-1:0]  w_op;
    logic signed [P_W-1:0] w_sq;

    always_comb begin
        if (i_cmd.sq_y) begin
            w_op = r_sy;
        end else if (i_cmd.sq_z) begin
            w_op = r_sz;
        end else begin
            w_op = r_sx;
        end
    end

    assign w_sq = P_W'(w_op) * P_W'(w_op);

    // CORDIC seed: vector (a, b) = (-x, y), pre-rotated into the right half plane
    logic signed [CW-1:0] w_a, w_b;
    logic signed [CW-1:0] w_x0, w_y0;
    logic signed [ZW-1:0] w_z0;

    assign w_a = -CW'(w_sx);
    assign w_b = CW'(w_sy);

    always_comb begin
        if (w_a[CW-1]) begin
            if (!w_b[CW-1]) begin
                w_x0 = w_b;
                w_y0 = -w_a;
                w_z0 = toa_pkg::Z_QUARTER;
            end else begin
                w_x0 = -w_b;
                w_y0 = w_a;
                w_z0 = -toa_pkg::Z_QUARTER;
            end
        end else begin
            w_x0 = w_a;
            w_y0 = w_b;
            w_z0 = '0;
        end
    end

    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;

    logic signed [CW-1:0] w_dx, w_dy;
    logic signed [ZW-1:0] w_atan;

    assign w_dx   = r_y >>> i_cmd.step;
    assign w_dy   = r_x >>> i_cmd.step;
    assign w_atan = toa_pkg::atan_q7(i_cmd.step);

    // rounding to whole degrees and wrap
    logic signed [ZW-1:0] w_q, w_qr, w_deg;
    logic signed [OW-1:0] w_o, w_ow;
    logic                 w_tilt_ok;

    assign w_q   = r_zero ? '0 : r_z;
    assign w_qr  = w_q + toa_pkg::ROUND_HALF;
    assign w_deg = w_qr >>> toa_pkg::ANGLE_FRAC;
    assign w_o   = OW'(toa_pkg::DEG_QUARTER) - OW'(w_deg);
    assign w_ow  = w_o[OW-1] ? (w_o + OW'(toa_pkg::DEG_FULL)) : w_o;

    assign w_tilt_ok = (((P_W+2)'(r_acc)) << toa_pkg::TILT_SHIFT) >= (P_W+2)'(r_zsq);

    logic [AW-1:0] r_res_angle, r_last_angle;
    logic          r_res_known, r_last_known;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx   <= w_sx;
            r_sy   <= w_sy;
            r_sz   <= w_sz;
            r_x    <= w_x0;
            r_y    <= w_y0;
            r_z    <= w_z0;
            r_zero <= (w_a == '0) && (w_b == '0);
        end
        if (i_cmd.sq_x) begin
            r_acc <= $unsigned(w_sq);
        end
        if (i_cmd.sq_y) begin
            r_acc <= r_acc + $unsigned(w_sq);
        end
        if (i_cmd.sq_z) begin
            r_zsq <= $unsigned(w_sq);
        end
        if (i_cmd.rot) begin
            if (!r_y[CW-1]) begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end
        end
        if (i_cmd.result) begin
            r_res_angle <= w_tilt_ok ? AW'($unsigned(w_ow)) : '0;
            r_res_known <= w_tilt_ok;
        end
    end

    // last orientation doubles as the output payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_last_known <= 1'b0;
        end else if (i_cmd.commit) begin
            r_last_angle <= r_res_angle;
            r_last_known <= r_res_known;
        end
    end

    assign o_stat.changed = (r_res_angle != r_last_angle) || (r_res_known != r_last_known);
    assign o_angle_deg    = r_last_angle;
    assign o_angle_known  = r_last_known;

endmodule

[hw/rtl/tilt_orientation_angle.sv]
// A sample goes through load, the shared squarer (three passes: x, y, z), the single
// iterative CORDIC stage, the result step and the emit step; no new sample is taken
// until it is through, and none while a result stalls.
// A sample that leaves the orientation unchanged gives no result beat.
// Reset: synchronous, active low; clears the controller, the output valid and the
// stored orientation to unknown at 0 degrees.
module tilt_orientation_angle #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    toa_in_if.sink     i_in,
    toa_out_if.source  o_out
);

    // Controller: sequences load, three squarer passes (x, y, z), the rotation
    // loop and the result/emit steps. It holds the output valid flag, so a new
    // result is only committed when the previous beat has gone or goes now.
    toa_pkg::t_dp_cmd  w_cmd;
    toa_pkg::t_dp_stat w_stat;

    toa_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: exact tilt test 4*(x^2 + y^2) >= z^2, vectoring CORDIC for the
    // angle in Q7 degrees, rounding, 90 - angle with wrap, and the stored last
    // orientation, which is also the output payload register.
    toa_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_accel_x     (i_in.accel_x),
        .i_accel_y     (i_in.accel_y),
        .i_accel_z     (i_in.accel_z),
        .o_stat        (w_stat),
        .o_angle_deg   (o_out.angle_deg),
        .o_angle_known (o_out.angle_known)
    );

endmodule

[hw/rtl/toa_checker.sv]
module toa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [toa_pkg::ANGLE_W-1:0]  i_angle_deg,
    input logic                         i_angle_known
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_angle_deg) && $stable(i_angle_known))
        else $error("result beat changed while stalled");

    // reset drops the result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one sample in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while busy");

    // a fresh result appears as the block goes back to taking samples
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result raised while busy");

endmodule

bind tilt_orientation_angle toa_checker u_toa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_angle_deg   (o_out.angle_deg),
    .i_angle_known (o_out.angle_known)
);
